/* rtl/core/ipv4_host_port_text_parser_assert.svh */
// Assertion macros shared by the host:port text parser RTL.
// Needs nothing else; include it inside a module body.
`ifndef IPV4_HOST_PORT_TEXT_PARSER_ASSERT_SVH
`define IPV4_HOST_PORT_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPV4HP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPV4HP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ipv4hp_pkg.sv */
// Package for the host:port text parser: widths, character codes, phases and
// the parse state record. Used by the interfaces and every RTL module.
package ipv4hp_pkg;

    localparam int CHAR_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int ERR_W      = 3;
    localparam int ACC_W      = 16;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [PORT_W-1:0]     DEFAULT_PORT_RESET = 16'd8001;
    localparam logic [APB_ADDR_W-1:0] REG_DEFAULT_PORT   = 2'd0;

    localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] ASCII_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;

    localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PORT = 3'd5;

    typedef enum logic [2:0] {
        PH_SEC0,
        PH_SEC1,
        PH_SEC2,
        PH_SEC3,
        PH_AFTER,
        PH_PORT,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                seen;
        logic [ACC_W-1:0]    acc;
        logic [ADDR_W-1:0]   addr;
        logic [PORT_W-1:0]   port;
        logic [ERR_W-1:0]    err;
    } t_parse_state;

endpackage

/* rtl/core/ipv4hp_if.sv */
// Request channels of the host:port text parser: characters in, results out.
// Depends on ipv4hp_pkg for the field widths.
interface ipv4hp_char_if
    import ipv4hp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface ipv4hp_result_if
    import ipv4hp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port_number;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, output address, output port_number, output error_code,
                    input ready);
    modport sink   (input valid, input address, input port_number, input error_code,
                    output ready);
endinterface

/* rtl/core/ipv4_host_port_text_parser.sv */
// Top level of the IPv4 host:port text parser with its APB default-port register.
// Depends on ipv4hp_pkg, ipv4hp_if, ipv4hp_step and the assertion macro header.
//
// Usage: the text a.b.c.d[:port] arrives one character per request on i_char,
// with final_char set on its last character. For each final character one result
// request leaves on o_result: the address (first section in bits 31..24), the
// port (default_port when no colon follows the fourth section) and an error
// code (1..4 for an empty section, 2..4 for a first to third section not ended
// by a dot, 5 for an empty port). Characters after the outcome is decided are
// swallowed until the final one.
// A final character is held in the input register and its result is then loaded
// into the result register, from which it is offered on o_result.
// Throughput: one character per cycle unless a final one waits; the combinational
// multiply-by-ten and add on the 16-bit accumulator sit in the step logic.
// Stalls: the result register parts the two sides. Non-final characters keep
// flowing while a result waits; a final character waits in the input register
// until the result register is free or is being emptied.
// Reset (synchronous, active low) clears the parse state and both valid flags
// and sets default_port to 8001. default_port lies at byte address 0 of the APB
// port; it should be written only while the block is idle.
module ipv4_host_port_text_parser
    import ipv4hp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipv4hp_char_if.sink           i_char,
    ipv4hp_result_if.source       o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    `include "ipv4_host_port_text_parser_assert.svh"

    // Configuration register.
    logic [PORT_W-1:0] r_default_port;
    logic              cfg_write;

    // Input register stage.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char_code;
    logic              r_final_char;

    // Running parse state, carried from one character to the next.
    t_parse_state      r_state;
    t_parse_state      n_state;

    // Result register stage.
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_address;
    logic [PORT_W-1:0] r_out_port;
    logic [ERR_W-1:0]  r_out_error;

    logic [ADDR_W-1:0] n_address;
    logic [PORT_W-1:0] n_port;
    logic [ERR_W-1:0]  n_error;

    logic              advance;
    logic              in_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_DEFAULT_PORT);
    assign prdata    = (paddr == REG_DEFAULT_PORT)
                     ? {{(APB_DATA_W-PORT_W){1'b0}}, r_default_port} : '0;

    // The character in the input register moves on unless it is final and the
    // result register is still holding an untaken result.
    assign advance      = r_in_valid && (!r_final_char || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || advance;
    assign in_take      = i_char.valid && i_char.ready;

    ipv4hp_step u_step (
        .i_state        (r_state),
        .i_char_code    (r_char_code),
        .i_final_char   (r_final_char),
        .i_default_port (r_default_port),
        .o_next_state   (n_state),
        .o_address      (n_address),
        .o_port_number  (n_port),
        .o_error_code   (n_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_port <= DEFAULT_PORT_RESET;
        end else if (cfg_write) begin
            r_default_port <= pwdata[PORT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char_code  <= i_char.char_code;
            r_final_char <= i_char.final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_final_char) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_final_char) begin
            r_out_address <= n_address;
            r_out_port    <= n_port;
            r_out_error   <= n_error;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.address     = r_out_address;
    assign o_result.port_number = r_out_port;
    assign o_result.error_code  = r_out_error;

    // An error result carries neither an address nor a port.
    `IPV4HP_ASSERT_IMP(a_err_zero_fields, i_clk, i_rst_n,
        r_out_valid && (r_out_error != ERR_NONE),
        (r_out_address == '0) && (r_out_port == '0),
        "error result with nonzero address or port")

    // Only codes 0 to 5 are ever produced.
    `IPV4HP_ASSERT_IMP(a_err_range, i_clk, i_rst_n,
        r_out_valid,
        r_out_error <= ERR_PORT,
        "error code out of range")

    // A final character blocked by a full result register stays put.
    `IPV4HP_ASSERT_NEXT(a_final_held, i_clk, i_rst_n,
        r_in_valid && r_final_char && r_out_valid && !o_result.ready,
        r_in_valid && r_final_char,
        "final character lost while result register was full")

    // The parse restarts from the first section after every final character.
    `IPV4HP_ASSERT_NEXT(a_restart, i_clk, i_rst_n,
        advance && r_final_char,
        (r_state.phase == PH_SEC0) && !r_state.seen && (r_state.acc == '0)
            && r_out_valid,
        "parse state not cleared after final character")

endmodule

/* rtl/core/ipv4hp_step.sv */
// Combinational next-state and result logic for one character of the parser.
// Depends on ipv4hp_pkg for the parse state record and character codes.
module ipv4hp_step
    import ipv4hp_pkg::*;
(
    input  t_parse_state        i_state,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic                i_final_char,
    input  logic [PORT_W-1:0]   i_default_port,
    output t_parse_state        o_next_state,
    output logic [ADDR_W-1:0]   o_address,
    output logic [PORT_W-1:0]   o_port_number,
    output logic [ERR_W-1:0]    o_error_code
);

    // One character against the parse state. A non-dot character that ends a
    // section is looked at again by the following phase, which is folded in here.
    function automatic t_parse_state feed(input t_parse_state s,
                                          input logic [CHAR_W-1:0] c,
                                          input logic [PORT_W-1:0] dflt);
        t_parse_state     n;
        logic             is_digit;
        logic [1:0]       idx;
        logic [1:0]       byte_sel;
        logic [ACC_W-1:0] acc10;
        n        = s;
        is_digit = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
        idx      = s.phase[1:0];
        byte_sel = ~idx;
        acc10    = (s.acc << 3) + (s.acc << 1) + {{(ACC_W-4){1'b0}}, c[3:0]};
        unique case (s.phase) inside
            PH_SEC0, PH_SEC1, PH_SEC2, PH_SEC3: begin
                if (is_digit) begin
                    n.acc  = acc10;
                    n.seen = 1'b1;
                end else if (!s.seen) begin
                    n.err   = {1'b0, idx} + 3'd1;
                    n.phase = PH_DONE;
                end else begin
                    n.addr[{byte_sel, 3'b000} +: 8] = s.acc[7:0];
                    n.acc  = '0;
                    n.seen = 1'b0;
                    if (c == ASCII_DOT) begin
                        n.phase = t_phase'(s.phase + 3'd1);
                    end else if (idx != 2'd3) begin
                        n.err   = {1'b0, idx} + 3'd2;
                        n.phase = PH_DONE;
                    end else if (c == ASCII_COLON) begin
                        n.phase = PH_PORT;
                    end else begin
                        n.port  = dflt;
                        n.phase = PH_DONE;
                    end
                end
            end
            PH_AFTER: begin
                if (c == ASCII_COLON) begin
                    n.phase = PH_PORT;
                    n.acc   = '0;
                    n.seen  = 1'b0;
                end else begin
                    n.port  = dflt;
                    n.phase = PH_DONE;
                end
            end
            PH_PORT: begin
                if (is_digit) begin
                    n.acc  = acc10;
                    n.seen = 1'b1;
                end else if (s.seen) begin
                    n.port  = s.acc;
                    n.phase = PH_DONE;
                end else begin
                    n.err   = ERR_PORT;
                    n.phase = PH_DONE;
                end
            end
            default: begin
                n = s;
            end
        endcase
        return n;
    endfunction

    t_parse_state after_char;
    t_parse_state after_end;

    always_comb begin
        after_char = feed(i_state, i_char_code, i_default_port);
        after_end  = feed(after_char, ASCII_NUL, i_default_port);

        o_next_state = i_final_char ? t_parse_state'('0) : after_char;

        if (after_end.err != ERR_NONE) begin
            o_address     = '0;
            o_port_number = '0;
        end else begin
            o_address     = after_end.addr;
            o_port_number = after_end.port;
        end
        o_error_code = after_end.err;
    end

endmodule
